@@ hdl/htr_pkg.sv @@
// shared types, register codes and helper functions for the hill tensor rotation unit
package htr_pkg;

  typedef logic signed [31:0] word_t;
  typedef word_t [8:0] rot_mat_t;
  typedef logic signed [34:0] tval_t;
  typedef tval_t [5:0] trow_t;

  localparam logic [2:0] REG_HILL_F = 3'd0;
  localparam logic [2:0] REG_HILL_G = 3'd1;
  localparam logic [2:0] REG_HILL_H = 3'd2;
  localparam logic [2:0] REG_HILL_L = 3'd3;
  localparam logic [2:0] REG_HILL_M = 3'd4;
  localparam logic [2:0] REG_HILL_N = 3'd5;

  localparam logic [2:0] LAST_IDX = 3'd5;
  localparam logic signed [31:0] HILL_RESET = 32'sh0100_0000;

  // operand selection for one entry of the 6x6 transformation
  typedef struct packed {
    logic [3:0] a0;
    logic [3:0] b0;
    logic [3:0] a1;
    logic [3:0] b1;
    logic       dbl;
    logic       two;
  } ops_t;

  function automatic logic [1:0] htr_u(input logic [1:0] i);
    case (i)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] htr_v(input logic [1:0] i);
    case (i)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] htr_ia(input logic [1:0] i);
    return (i == 2'd0) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] htr_ib(input logic [1:0] i);
    return (i == 2'd2) ? 2'd1 : 2'd2;
  endfunction

  function automatic logic [3:0] htr_at(input logic [1:0] r, input logic [1:0] c);
    return 4'({2'b00, r} * 4'd3 + {2'b00, c});
  endfunction

  function automatic ops_t htr_ops(input logic [2:0] row, input logic [2:0] col);
    ops_t o;
    logic [1:0] i;
    logic [1:0] j;
    o = '0;
    i = (row >= 3'd3) ? 2'(row - 3'd3) : row[1:0];
    j = (col >= 3'd3) ? 2'(col - 3'd3) : col[1:0];
    if (row < 3'd3 && col < 3'd3) begin
      o.a0 = htr_at(i, j);
      o.b0 = htr_at(i, j);
    end else if (row < 3'd3) begin
      o.a0 = htr_at(i, htr_u(j));
      o.b0 = htr_at(i, htr_v(j));
    end else if (col < 3'd3) begin
      o.a0  = htr_at(htr_u(i), j);
      o.b0  = htr_at(htr_v(i), j);
      o.dbl = 1'b1;
    end else begin
      o.a0  = htr_at(htr_ia(i), htr_ia(j));
      o.b0  = htr_at(htr_ib(i), htr_ib(j));
      o.a1  = htr_at(htr_ia(i), htr_ib(j));
      o.b1  = htr_at(htr_ib(i), htr_ia(j));
      o.two = 1'b1;
    end
    return o;
  endfunction

  // round half up, then arithmetic shift by 29 (doubled terms) or 30
  function automatic tval_t htr_rnd(input logic signed [63:0] p, input logic dbl);
    logic signed [64:0] s;
    logic signed [64:0] q;
    s = {p[63], p} + (dbl ? 65'sh1000_0000 : 65'sh2000_0000);
    q = dbl ? (s >>> 29) : (s >>> 30);
    return tval_t'(q);
  endfunction

endpackage

@@ hdl/htr_trow.sv @@
// one row of the 6x6 transformation matrix, two register stages
module htr_trow (
  input  logic              clk,
  input  logic              en,
  input  htr_pkg::rot_mat_t rot,
  input  logic [2:0]        row_idx,
  output htr_pkg::trow_t    t_row
);
  import htr_pkg::*;

  ops_t              ops [6];
  logic signed [63:0] prod0 [6];
  logic signed [63:0] prod1 [6];
  logic              dbl [6];
  logic              two [6];
  trow_t             t_row_next;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ops[k] = htr_ops(row_idx, 3'(k));
    end
  end

  // products stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        prod0[k] <= $signed(rot[ops[k].a0]) * $signed(rot[ops[k].b0]);
        prod1[k] <= $signed(rot[ops[k].a1]) * $signed(rot[ops[k].b1]);
        dbl[k]   <= ops[k].dbl;
        two[k]   <= ops[k].two;
      end
    end
  end

  // rounding stage
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      t_row_next[k] = htr_rnd(prod0[k], dbl[k]) +
                      (two[k] ? htr_rnd(prod1[k], 1'b0) : tval_t'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_row <= t_row_next;
    end
  end

endmodule

@@ hdl/hill_tensor_rotation_unit.sv @@
// top level: rotated 6x6 hill tensor, one entry per beat
// entries go through the issue stage, then stages 1..7; one beat per cycle unless stalled
// a new item is taken when the single entry-issue counter is idle or on its last entry
// the 7-stage entry pipeline advances as a whole; a stalled output holds every stage
// reset clears the issue counter and all valid bits; hill constants return to 1.0
module hill_tensor_rotation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] rot_00,
  input  logic signed [31:0] rot_01,
  input  logic signed [31:0] rot_02,
  input  logic signed [31:0] rot_10,
  input  logic signed [31:0] rot_11,
  input  logic signed [31:0] rot_12,
  input  logic signed [31:0] rot_20,
  input  logic signed [31:0] rot_21,
  input  logic signed [31:0] rot_22,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [47:0] tensor_value,
  output logic               saturated,
  output logic               last_entry
);
  import htr_pkg::*;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
  } tag_t;

  localparam logic signed [49:0] SAT_HI = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SAT_LO = -50'sh0_8000_0000_0000;

  // hill constants
  logic signed [31:0] hill_f, hill_g, hill_h, hill_l, hill_m, hill_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      hill_f <= HILL_RESET;
      hill_g <= HILL_RESET;
      hill_h <= HILL_RESET;
      hill_l <= HILL_RESET;
      hill_m <= HILL_RESET;
      hill_n <= HILL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HILL_F: hill_f <= cfg_data;
        REG_HILL_G: hill_g <= cfg_data;
        REG_HILL_H: hill_h <= cfg_data;
        REG_HILL_L: hill_l <= cfg_data;
        REG_HILL_M: hill_m <= cfg_data;
        REG_HILL_N: hill_n <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being drained
  logic en;
  assign en = !out_valid || !out_stall;

  // issue stage: holds the rotation and walks the 36 entries
  rot_mat_t   rot;
  logic [2:0] cur_row, cur_col;
  logic       active;
  logic       at_end;
  logic       take;

  assign at_end   = (cur_row == LAST_IDX) && (cur_col == LAST_IDX);
  assign in_stall = !(en && (!active || at_end));
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      cur_row <= '0;
      cur_col <= '0;
    end else if (en) begin
      if (take) begin
        active  <= 1'b1;
        cur_row <= '0;
        cur_col <= '0;
      end else if (active) begin
        if (at_end) begin
          active <= 1'b0;
        end else if (cur_col == LAST_IDX) begin
          cur_col <= '0;
          cur_row <= cur_row + 3'd1;
        end else begin
          cur_col <= cur_col + 3'd1;
        end
      end
    end
  end

  // rotation payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      rot <= {rot_22, rot_21, rot_20, rot_12, rot_11, rot_10, rot_02, rot_01, rot_00};
    end
  end

  // valid bits and entry tags travel alongside the data, stages 1..7
  logic vld [1:7];
  tag_t tag [1:7];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 7; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= active;
      for (int s = 2; s <= 7; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[1] <= '{row: cur_row, col: cur_col, last: at_end};
      for (int s = 2; s <= 7; s++) begin
        tag[s] <= tag[s-1];
      end
    end
  end

  // stages 1-2: transformation rows for the entry's row and column
  trow_t tr, tc;

  htr_trow u_trow_r (.clk(clk), .en(en), .rot(rot), .row_idx(cur_row), .t_row(tr));
  htr_trow u_trow_c (.clk(clk), .en(en), .rot(rot), .row_idx(cur_col), .t_row(tc));

  // hill matrix: 3x3 normal block plus the shear diagonal
  logic signed [32:0] pk [3][3];
  logic signed [32:0] pd [3];

  always_comb begin
    pk[0][0] = {hill_g[31], hill_g} + {hill_h[31], hill_h};
    pk[1][1] = {hill_f[31], hill_f} + {hill_h[31], hill_h};
    pk[2][2] = {hill_f[31], hill_f} + {hill_g[31], hill_g};
    pk[0][1] = -{hill_h[31], hill_h};
    pk[1][0] = pk[0][1];
    pk[0][2] = -{hill_g[31], hill_g};
    pk[2][0] = pk[0][2];
    pk[1][2] = -{hill_f[31], hill_f};
    pk[2][1] = pk[1][2];
    pd[0]    = {hill_n, 1'b0};
    pd[1]    = {hill_l, 1'b0};
    pd[2]    = {hill_m, 1'b0};
  end

  // stage 3: products of the T row with the hill matrix
  logic signed [67:0] ap [6][3];
  trow_t tc3, tc4;

  always_ff @(posedge clk) begin
    if (en) begin
      tc3 <= tc;
      for (int l = 0; l < 3; l++) begin
        for (int k = 0; k < 3; k++) begin
          ap[l][k] <= tr[k] * pk[k][l];
        end
        ap[l+3][0] <= tr[l+3] * pd[l];
        ap[l+3][1] <= '0;
        ap[l+3][2] <= '0;
      end
    end
  end

  // stage 4: one row of T*P, rounded to Q.24
  logic signed [69:0] asum [6];
  logic signed [39:0] arow [6];

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      asum[l] = 70'(ap[l][0]) + 70'(ap[l][1]) + 70'(ap[l][2]) + 70'sh2000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tc4 <= tc3;
      for (int l = 0; l < 6; l++) begin
        arow[l] <= 40'(asum[l] >>> 30);
      end
    end
  end

  // stage 5: split partial products against the T column row
  logic signed [57:0] ph [6];
  logic signed [57:0] pl [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        ph[l] <= arow[l] * $signed(tc4[l][34:17]);
        pl[l] <= arow[l] * $signed({1'b0, tc4[l][16:0]});
      end
    end
  end

  // stage 6: accumulate the high and low halves
  logic signed [60:0] sh_next, sl_next, sh, sl;

  always_comb begin
    sh_next = '0;
    sl_next = '0;
    for (int l = 0; l < 6; l++) begin
      sh_next = sh_next + 61'(ph[l]);
      sl_next = sl_next + 61'(pl[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh <= sh_next;
      sl <= sl_next;
    end
  end

  // stage 7: recombine, round half up, saturate into the output register
  logic signed [79:0] total;
  logic signed [49:0] vfull;

  assign total = (80'(sh) <<< 17) + 80'(sl) + 80'sh2000_0000;
  assign vfull = 50'(total >>> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      if (vfull > SAT_HI) begin
        tensor_value <= 48'(SAT_HI);
        saturated    <= 1'b1;
      end else if (vfull < SAT_LO) begin
        tensor_value <= 48'(SAT_LO);
        saturated    <= 1'b1;
      end else begin
        tensor_value <= 48'(vfull);
        saturated    <= 1'b0;
      end
    end
  end

  assign out_valid  = vld[7];
  assign out_row    = tag[7].row;
  assign out_col    = tag[7].col;
  assign last_entry = tag[7].last;

  // a new item always starts its walk at entry zero
  a_take_start: assert property (@(posedge clk) disable iff (rst)
    take |=> active && cur_row == 3'd0 && cur_col == 3'd0)
    else $error("issue counter did not restart on a new item");

  // the flagged beat is the bottom right entry
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_entry |-> out_row == LAST_IDX && out_col == LAST_IDX)
    else $error("last beat flagged at wrong position");

  // a clipped value sits exactly on a limit
  a_sat_lim: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      tensor_value == 48'(SAT_HI) || tensor_value == 48'(SAT_LO))
    else $error("saturated flag without a limit value");

endmodule
